@@ hw/rtl/att_pkg.sv @@
`default_nettype none

package att_pkg;

    localparam int RAW_W  = 16;
    localparam int ACC_W  = 20;
    localparam int ANG_W  = 9;
    localparam int QUO_W  = 6;
    localparam int SUM_W  = 26;
    localparam int CNT_W  = 3;

    localparam logic [ANG_W-1:0] DEG_90  = 9'd90;
    localparam logic [ANG_W-1:0] DEG_180 = 9'd180;
    localparam logic [QUO_W-1:0] DEG_45  = 6'd45;

    // Sensor kind codes held in the configuration register
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_8BIT  = 2'd1,
        KIND_16BIT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_ANGLE,
        ST_HOLD
    } t_state;

    typedef enum logic [1:0] {
        ANG_IDLE,
        ANG_PREP,
        ANG_DIV,
        ANG_FIN
    } t_ang_state;

    typedef struct packed {
        logic                    status;
        logic signed [RAW_W-1:0] mx;
        logic signed [RAW_W-1:0] my;
        logic signed [RAW_W-1:0] mz;
    } t_sample;

endpackage

`default_nettype wire

@@ hw/rtl/accel_tilt_filter.sv @@
// Channel   Dir  Handshake                  Payload
// s (in)    in   i_s_tvalid / o_s_tready    tdata: raw_a, raw_b, raw_c; tuser: read_ok
// m (out)   out  o_m_tvalid / i_m_tready    tdata: mounted x/y/z, smooth x/y/z, pitch, roll;
//                                           tuser: status
// cfg       in   i_cfg_valid / o_cfg_ready  data: sensor_kind
//
// An item passes from its input transfer to its result in the output register
// through angle start, prepare, six-step serial divide, finish and output load;
// the divider gives one quotient bit a cycle. The input reopens the cycle after
// the output load, so a new item is taken only once the last one is through.
// A stalled output holds the next result in the core until it drains.
// Reset (synchronous, active low) clears the accumulators and sensor kind.
`default_nettype none

module accel_tilt_filter
    import att_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config write
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_data,    // sensor_kind
    // input stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [47:0]  i_s_tdata,     // raw_a[15:0], raw_b[31:16], raw_c[47:32]
    input  wire logic         i_s_tuser,     // read_ok
    // output stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [127:0]      o_m_tdata,     // mounted_x[15:0], mounted_y[31:16],
                                             // mounted_z[47:32], smooth_x[67:48],
                                             // smooth_y[87:68], smooth_z[107:88],
                                             // pitch_deg[116:108], roll_deg[125:117], zero
    output logic              o_m_tuser      // status
);

    t_state r_state;
    t_state n_state;

    logic [1:0] r_kind;

    t_sample sample;
    t_sample r_smp;

    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] acc_z;

    logic                    pitch_done;
    logic                    roll_done;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] r_pitch;
    logic signed [ANG_W-1:0] r_roll;

    logic         r_out_valid;
    logic [127:0] r_out_data;
    logic         r_out_user;

    logic in_xfer;
    logic ang_start;
    logic out_load;

    // Configuration is always taken; it is to be written only while idle, which the block itself does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_NONE;
        end else if (i_cfg_valid) begin
            r_kind <= i_cfg_data;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;

    att_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_kind    (r_kind),
        .i_read_ok (i_s_tuser),
        .i_raw_a   (i_s_tdata[15:0]),
        .i_raw_b   (i_s_tdata[31:16]),
        .i_raw_c   (i_s_tdata[47:32]),
        .i_update  (in_xfer),
        .o_sample  (sample),
        .o_acc_x   (acc_x),
        .o_acc_y   (acc_y),
        .o_acc_z   (acc_z)
    );

    // Pitch from smoothed X over Z, roll from smoothed Y over Z
    att_angle u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ang_start),
        .i_num   (acc_x),
        .i_den   (acc_z),
        .o_done  (pitch_done),
        .o_angle (pitch)
    );

    att_angle u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ang_start),
        .i_num   (acc_y),
        .i_den   (acc_z),
        .o_done  (roll_done),
        .o_angle (roll)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        ang_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                // accumulators are updated by now: launch both angles
                ang_start = 1'b1;
                n_state   = ST_ANGLE;
            end
            ST_ANGLE: begin
                if (pitch_done && roll_done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sample and angle holding registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_smp <= sample;
        end
        if (pitch_done) begin
            r_pitch <= pitch;
        end
        if (roll_done) begin
            r_roll <= roll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {2'b00, r_roll, r_pitch, acc_z, acc_y, acc_x,
                           r_smp.mz, r_smp.my, r_smp.mx};
            r_out_user <= r_smp.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // Both angle units run in lockstep
    a_ang_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pitch_done == roll_done)
        else $error("angle units out of step");

    // An accepted item keeps the input closed for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_s_tready)
        else $error("input reopened straight after a transfer");

    // An error result carries zero mounted fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[47:0] == 48'd0))
        else $error("error result with non-zero sample");

    // Angles stay inside a half turn either way
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[116:108]) >= -9'sd180 &&
                        $signed(o_m_tdata[116:108]) <= 9'sd180 &&
                        $signed(o_m_tdata[125:117]) >= -9'sd180 &&
                        $signed(o_m_tdata[125:117]) <= 9'sd180))
        else $error("angle out of range");

endmodule

`default_nettype wire

@@ hw/rtl/att_front.sv @@
`default_nettype none

module att_front
    import att_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [1:0]              i_kind,
    input  wire logic                    i_read_ok,
    input  wire logic signed [RAW_W-1:0] i_raw_a,
    input  wire logic signed [RAW_W-1:0] i_raw_b,
    input  wire logic signed [RAW_W-1:0] i_raw_c,
    input  wire logic                    i_update,
    output t_sample                      o_sample,
    output logic signed [ACC_W-1:0]      o_acc_x,
    output logic signed [ACC_W-1:0]      o_acc_y,
    output logic signed [ACC_W-1:0]      o_acc_z
);

    logic signed [ACC_W-1:0] r_acc_x;
    logic signed [ACC_W-1:0] r_acc_y;
    logic signed [ACC_W-1:0] r_acc_z;

    logic signed [RAW_W-1:0] a8;
    logic signed [RAW_W-1:0] b8;
    logic signed [RAW_W-1:0] c8;

    // (acc*15 + v*16) >>> 4, kept to the accumulator width
    function automatic logic signed [ACC_W-1:0] lowpass(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [RAW_W-1:0] v
    );
        logic signed [SUM_W-1:0] sum;
        sum = (SUM_W'(acc) <<< 4) - SUM_W'(acc) + (SUM_W'(v) <<< 4);
        return sum[ACC_W+3:4];
    endfunction

    assign a8 = {{8{i_raw_a[7]}}, i_raw_a[7:0]};
    assign b8 = {{8{i_raw_b[7]}}, i_raw_b[7:0]};
    assign c8 = {{8{i_raw_c[7]}}, i_raw_c[7:0]};

    always_comb begin
        o_sample = '{status: 1'b1, mx: '0, my: '0, mz: '0};
        if (i_read_ok) begin
            case (i_kind)
                KIND_8BIT: begin
                    o_sample.status = 1'b0;
                    o_sample.mx     = -a8;
                    o_sample.my     = -b8;
                    o_sample.mz     = c8;
                end
                KIND_16BIT: begin
                    o_sample.status = 1'b0;
                    o_sample.mx     = -i_raw_b;
                    o_sample.my     = -i_raw_a;
                    o_sample.mz     = i_raw_c;
                end
                default: begin
                    o_sample.status = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end else if (i_update && !o_sample.status) begin
            r_acc_x <= lowpass(r_acc_x, o_sample.mx);
            r_acc_y <= lowpass(r_acc_y, o_sample.my);
            r_acc_z <= lowpass(r_acc_z, o_sample.mz);
        end
    end

    assign o_acc_x = r_acc_x;
    assign o_acc_y = r_acc_y;
    assign o_acc_z = r_acc_z;

endmodule

`default_nettype wire

@@ hw/rtl/att_angle.sv @@
`default_nettype none

module att_angle
    import att_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [ACC_W-1:0] i_num,
    input  wire logic signed [ACC_W-1:0] i_den,
    output logic                         o_done,
    output logic signed [ANG_W-1:0]      o_angle
);

    t_ang_state r_state;
    t_ang_state n_state;

    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_ay;
    logic [ACC_W-1:0] r_ax;
    logic             r_num_neg;
    logic             r_den_neg;
    logic             r_zero;
    logic             r_steep;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_q;

    logic             ge;
    logic [ACC_W-1:0] small_mag;
    logic [ACC_W-1:0] big_mag;
    logic [ANG_W-1:0] base;
    logic [ANG_W-1:0] half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ANG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        case (r_state)
            ANG_IDLE: begin
                if (i_start) begin
                    n_state = ANG_PREP;
                end
            end
            ANG_PREP: begin
                n_state = ANG_DIV;
            end
            ANG_DIV: begin
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    n_state = ANG_FIN;
                end
            end
            ANG_FIN: begin
                o_done  = 1'b1;
                n_state = ANG_IDLE;
            end
            default: begin
                n_state = ANG_IDLE;
            end
        endcase
    end

    assign small_mag = (r_ax < r_ay) ? r_ax : r_ay;
    assign big_mag   = (r_ax < r_ay) ? r_ay : r_ax;
    assign ge        = (r_rem >= r_dsh);

    // Restoring divide, one quotient bit a cycle; the quotient never exceeds 45
    always_ff @(posedge i_clk) begin
        case (r_state)
            ANG_IDLE: begin
                r_ay      <= i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
                r_ax      <= i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);
                r_num_neg <= i_num[ACC_W-1];
                r_den_neg <= i_den[ACC_W-1];
                r_zero    <= (i_num == '0) && (i_den == '0);
            end
            ANG_PREP: begin
                r_steep <= (r_ax < r_ay);
                r_rem   <= SUM_W'(small_mag) * SUM_W'(DEG_45);
                r_dsh   <= {1'b0, big_mag, {(QUO_W-1){1'b0}}};
                r_q     <= '0;
                r_cnt   <= '0;
            end
            ANG_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[QUO_W-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // Fold the first-octant quotient out to the full circle
    always_comb begin
        base = r_steep ? (DEG_90 - ANG_W'(r_q)) : ANG_W'(r_q);
        half = r_den_neg ? (DEG_180 - base) : base;
        if (r_zero) begin
            o_angle = '0;
        end else if (r_num_neg) begin
            o_angle = -$signed(half);
        end else begin
            o_angle = $signed(half);
        end
    end

endmodule

`default_nettype wire
